// File: sv/bpht_pkg.sv
// shared constants and types for the bounded probe hash table
package bpht_pkg;

	localparam int unsigned INDEX_BITS_DEF  = 10;
	localparam int unsigned PROBE_LIMIT_DEF = 16;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
	localparam int unsigned MIX_S1 = 30;
	localparam int unsigned MIX_S2 = 27;
	localparam int unsigned MIX_S3 = 31;

	localparam logic [2:0] CMD_LOOKUP = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_INC    = 3'd2;
	localparam logic [2:0] CMD_DEC    = 3'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [10:0] COUNT_MAX = 11'd2047;
	localparam logic [15:0] REFS_MAX  = 16'hffff;

	typedef struct packed {
		logic [10:0] entry_count;
		logic [1:0]  status;
		logic [15:0] refcount_out;
		logic [9:0]  slot_out;
		logic [63:0] length_out;
		logic [63:0] ptr_out;
		logic        found;
	} result_t;

endpackage

// File: sv/bpht_ram.sv
// generic single write port ram with registered read
module bpht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/bounded_probe_hash_table_core.sv
// bounded probe hash table core: sequencer, shared multiplier and table memory
//
// Hash table of 2^INDEX_BITS reference counted entries, one command per beat.
// After reset the table memory is cleared one slot per cycle, all 2^INDEX_BITS
// slots (1024 by default), and no beat is taken until that is done. A
// searching command then hashes its key through one 32x32 multiplier (three
// partial products per 64-bit multiply), reads each probed slot from the
// single-port-read table memory, makes up to two table writes and loads the
// result; the default probe limit is 16. A command through a given slot
// skips the hash and reads only that slot; a reserved command goes straight
// to the result. One command is in flight at a time.
module bounded_probe_hash_table_core #(
	parameter int unsigned INDEX_BITS  = bpht_pkg::INDEX_BITS_DEF,
	parameter int unsigned PROBE_LIMIT = bpht_pkg::PROBE_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key[63:0], use_slot[64], slot[74:65], ptr_value[138:75], length[202:139], zero pad
	input  logic [207:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found[0], ptr_out[64:1], length_out[128:65], slot_out[138:129],
	// refcount_out[154:139], status[156:155], entry_count[167:157]
	output logic [167:0] m_tdata
);

	localparam int unsigned LPW = $clog2(PROBE_LIMIT);

	typedef struct packed {
		logic [63:0]    key;
		logic [63:0]    ptr;
		logic [63:0]    len;
		logic [LPW-1:0] lp;
		logic [15:0]    refs;
	} entry_t;

	localparam int unsigned EW = $bits(entry_t);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_X30, S_MUL, S_X27, S_X31,
		S_RD, S_CHK, S_HOME_WR, S_ENT_WR, S_DONE
	} state_t;

	state_t                state_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic [2:0]            cmd_q;
	logic                  use_slot_q;
	logic [63:0]           key_q;
	logic [63:0]           ptr_q;
	logic [63:0]           len_q;
	logic [63:0]           x_q;
	logic [63:0]           acc_q;
	logic [63:0]           prod_q;
	logic [1:0]            mstep_q;
	logic                  msel_q;
	logic [INDEX_BITS-1:0] home_q;
	logic [INDEX_BITS-1:0] slot_q;
	logic [LPW-1:0]        d_q;
	logic [LPW-1:0]        home_lp_q;
	entry_t                home_e_q;
	entry_t                wr_q;
	logic [10:0]           live_q;
	bpht_pkg::result_t     res_q;
	logic                  m_tvalid_q;
	bpht_pkg::result_t     m_tdata_q;

	logic [INDEX_BITS-1:0] probe_addr;
	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;
	entry_t                rd_e;
	entry_t                op_e;
	entry_t                ins_e;
	entry_t                home_w;
	logic [10:0]           live_op;
	logic [LPW-1:0]        reach;
	logic                  hit;
	logic                  raise;
	logic                  search;
	logic [63:0]           mul_c;
	logic [31:0]           mul_a;
	logic [31:0]           mul_b;
	logic [63:0]           x31;
	bpht_pkg::result_t     res_init;

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign probe_addr = home_q + INDEX_BITS'(d_q);
	assign rd_e       = entry_t'(ram_rdata);

	// shared multiplier operand select
	assign mul_c = msel_q ? bpht_pkg::MIX_C2 : bpht_pkg::MIX_C1;
	assign mul_a = (mstep_q == 2'd2) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (mstep_q == 2'd1) ? mul_c[63:32] : mul_c[31:0];
	assign x31   = x_q ^ (x_q >> bpht_pkg::MIX_S3);

	assign reach  = (d_q == '0) ? rd_e.lp : home_lp_q;
	assign hit    = (rd_e.ptr != 64'd0) && (rd_e.key == key_q);
	assign raise  = (d_q > home_lp_q) && (d_q != '0);
	assign search = !use_slot_q || (cmd_q == bpht_pkg::CMD_LOOKUP);

	always_comb begin
		res_init             = '0;
		res_init.entry_count = live_q;
	end

	always_comb begin
		op_e    = rd_e;
		live_op = live_q;
		case (cmd_q)
			bpht_pkg::CMD_SET: begin
				op_e.ptr = ptr_q;
				op_e.len = len_q;
			end
			bpht_pkg::CMD_INC: begin
				if (rd_e.refs != bpht_pkg::REFS_MAX) begin
					op_e.refs = rd_e.refs + 16'd1;
				end
			end
			bpht_pkg::CMD_DEC: begin
				if (rd_e.refs != 16'd0) begin
					op_e.refs = rd_e.refs - 16'd1;
					if (rd_e.refs == 16'd1) begin
						op_e.key = '0;
						op_e.ptr = '0;
						op_e.len = '0;
						if (live_q != 11'd0) begin
							live_op = live_q - 11'd1;
						end
					end
				end
			end
			default: begin
				op_e = rd_e;
			end
		endcase
	end

	always_comb begin
		ins_e.key  = key_q;
		ins_e.ptr  = ptr_q;
		ins_e.len  = len_q;
		ins_e.lp   = (raise && probe_addr == home_q) ? d_q : rd_e.lp;
		ins_e.refs = 16'd1;
		home_w     = home_e_q;
		home_w.lp  = d_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = wr_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_HOME_WR: begin
				ram_we    = 1'b1;
				ram_waddr = home_q;
				ram_wdata = home_w;
			end
			S_ENT_WR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bpht_ram #(
		.WIDTH(EW),
		.DEPTH(2 ** INDEX_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(probe_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			live_q     <= '0;
			m_tvalid_q <= 1'b0;
			mstep_q    <= '0;
			msel_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + INDEX_BITS'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q      <= s_tuser;
						key_q      <= s_tdata[63:0];
						use_slot_q <= s_tdata[64];
						ptr_q      <= s_tdata[138:75];
						len_q      <= s_tdata[202:139];
						x_q        <= s_tdata[63:0];
						home_q     <= INDEX_BITS'(s_tdata[74:65]);
						d_q        <= '0;
						res_q      <= res_init;
						mstep_q    <= '0;
						msel_q     <= 1'b0;
						if (s_tuser > bpht_pkg::CMD_DEC) begin
							state_q <= S_DONE;
						end else if (s_tdata[64] && s_tuser != bpht_pkg::CMD_LOOKUP) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_X30;
						end
					end
				end
				S_X30: begin
					x_q     <= x_q ^ (x_q >> bpht_pkg::MIX_S1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= 64'(mul_a) * 64'(mul_b);
					mstep_q <= mstep_q + 2'd1;
					case (mstep_q)
						2'd1: acc_q <= prod_q;
						2'd2: acc_q <= acc_q + (prod_q << 32);
						2'd3: begin
							x_q     <= acc_q + (prod_q << 32);
							msel_q  <= !msel_q;
							state_q <= msel_q ? S_X31 : S_X27;
						end
						default: acc_q <= acc_q;
					endcase
				end
				S_X27: begin
					x_q     <= x_q ^ (x_q >> bpht_pkg::MIX_S2);
					state_q <= S_MUL;
				end
				S_X31: begin
					home_q  <= x31[63 -: INDEX_BITS];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (d_q == '0) begin
						home_lp_q <= rd_e.lp;
						home_e_q  <= rd_e;
					end
					if (!search || (cmd_q != bpht_pkg::CMD_SET && hit)) begin
						slot_q                 <= probe_addr;
						wr_q                   <= op_e;
						live_q                 <= live_op;
						res_q.found            <= 1'b1;
						res_q.ptr_out          <= op_e.ptr;
						res_q.length_out       <= op_e.len;
						res_q.slot_out         <= 10'(probe_addr);
						res_q.refcount_out     <= op_e.refs;
						res_q.status           <= bpht_pkg::ST_OK;
						res_q.entry_count      <= live_op;
						state_q <= (cmd_q == bpht_pkg::CMD_LOOKUP) ? S_DONE : S_ENT_WR;
					end else if (cmd_q == bpht_pkg::CMD_SET && rd_e.ptr == 64'd0) begin
						slot_q             <= probe_addr;
						wr_q               <= ins_e;
						res_q.found        <= 1'b1;
						res_q.ptr_out      <= ptr_q;
						res_q.length_out   <= len_q;
						res_q.slot_out     <= 10'(probe_addr);
						res_q.refcount_out <= 16'd1;
						res_q.status       <= bpht_pkg::ST_OK;
						if (live_q != bpht_pkg::COUNT_MAX) begin
							live_q            <= live_q + 11'd1;
							res_q.entry_count <= live_q + 11'd1;
						end else begin
							res_q.entry_count <= live_q;
						end
						state_q <= raise ? S_HOME_WR : S_ENT_WR;
					end else if (cmd_q == bpht_pkg::CMD_SET && d_q == LPW'(PROBE_LIMIT - 1)) begin
						res_q.status      <= bpht_pkg::ST_FULL;
						res_q.entry_count <= live_q;
						state_q           <= S_DONE;
					end else if (cmd_q != bpht_pkg::CMD_SET && d_q >= reach) begin
						res_q.status      <= bpht_pkg::ST_NOT_FOUND;
						res_q.entry_count <= live_q;
						state_q           <= S_DONE;
					end else begin
						d_q     <= d_q + LPW'(1);
						state_q <= S_RD;
					end
				end
				S_HOME_WR: begin
					state_q <= S_ENT_WR;
				end
				S_ENT_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !s_tready)
		else $error("table written while taking beats");

	a_live_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CHK) |=> (live_q == $past(live_q)))
		else $error("entry count changed outside probe check");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_DONE))
		else $error("result beat without finished command");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[156:155] == bpht_pkg::ST_OK))
		else $error("found result with error status");

endmodule

// File: dv/bounded_probe_hash_table_core_test.sv
// testbench for the bounded probe hash table core: predicted results checked beat by beat
module bounded_probe_hash_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = 1 << bpht_pkg::INDEX_BITS_DEF;
	localparam logic [2:0] CMD_NOP = 3'd4;
	localparam logic [2:0] CMD_RSV_LAST = 3'd7;
	localparam int LIMIT_CYCLES = 900000;

	// expected results kept in order, with a mismatch count
	class result_board;
		bpht_pkg::result_t pending[$];
		int mismatches;
		int unsigned noted;

		function void note(bpht_pkg::result_t r);
			pending.push_back(r);
			noted++;
		endfunction

		function void check(bpht_pkg::result_t got);
			bpht_pkg::result_t want;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", got);
				return;
			end
			want = pending.pop_front();
			bad = (want.found != got.found) || (want.ptr_out != got.ptr_out) ||
				(want.length_out != got.length_out) || (want.slot_out != got.slot_out) ||
				(want.refcount_out != got.refcount_out) || (want.status != got.status) ||
				(want.entry_count != got.entry_count);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [207:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [167:0] m_tdata;

	bounded_probe_hash_table_core uut (.*);

	result_board board;
	logic [63:0] tbl_key [SLOTS];
	logic [63:0] tbl_ptr [SLOTS];
	logic [63:0] tbl_len [SLOTS];
	logic [3:0] tbl_reach [SLOTS];
	logic [15:0] tbl_refs [SLOTS];
	logic [10:0] live;
	logic [63:0] known_keys [$];
	int stall_long;
	int cycles;

	function automatic logic [63:0] splitmix(logic [63:0] x);
		x = x ^ (x >> bpht_pkg::MIX_S1);
		x = x * bpht_pkg::MIX_C1;
		x = x ^ (x >> bpht_pkg::MIX_S2);
		x = x * bpht_pkg::MIX_C2;
		return x ^ (x >> bpht_pkg::MIX_S3);
	endfunction

	function automatic int home_slot(logic [63:0] k);
		logic [63:0] h;
		h = splitmix(k);
		return int'(h[63:64-bpht_pkg::INDEX_BITS_DEF]);
	endfunction

	function automatic int search_live(logic [63:0] k);
		int h;
		h = home_slot(k);
		for (int d = 0; d <= tbl_reach[h]; d++)
			if (tbl_ptr[(h + d) % SLOTS] != 0 && tbl_key[(h + d) % SLOTS] == k)
				return (h + d) % SLOTS;
		return -1;
	endfunction

	function automatic bpht_pkg::result_t table_step(logic [2:0] cmd, logic [63:0] k,
			logic us, logic [9:0] sl, logic [63:0] pv, logic [63:0] ln);
		bpht_pkg::result_t r;
		int s, h, d;
		r = '0;
		s = -1;
		if (cmd == bpht_pkg::CMD_LOOKUP) begin
			s = search_live(k);
			if (s < 0)
				r.status = bpht_pkg::ST_NOT_FOUND;
		end else if (cmd == bpht_pkg::CMD_SET) begin
			if (us) begin
				s = int'(sl);
				tbl_ptr[s] = pv;
				tbl_len[s] = ln;
			end else begin
				h = home_slot(k);
				for (d = 0; d < bpht_pkg::PROBE_LIMIT_DEF; d++)
					if (tbl_ptr[(h + d) % SLOTS] == 0) begin
						s = (h + d) % SLOTS;
						break;
					end
				if (s < 0)
					r.status = bpht_pkg::ST_FULL;
				else begin
					if (d > tbl_reach[h])
						tbl_reach[h] = 4'(d);
					tbl_key[s] = k;
					tbl_ptr[s] = pv;
					tbl_len[s] = ln;
					tbl_refs[s] = 16'd1;
					if (live < bpht_pkg::COUNT_MAX)
						live++;
				end
			end
		end else if (cmd == bpht_pkg::CMD_INC || cmd == bpht_pkg::CMD_DEC) begin
			s = us ? int'(sl) : search_live(k);
			if (s < 0)
				r.status = bpht_pkg::ST_NOT_FOUND;
			else if (cmd == bpht_pkg::CMD_INC) begin
				if (tbl_refs[s] < bpht_pkg::REFS_MAX)
					tbl_refs[s]++;
			end else if (tbl_refs[s] != 0) begin
				tbl_refs[s]--;
				if (tbl_refs[s] == 0) begin
					tbl_key[s] = '0;
					tbl_ptr[s] = '0;
					tbl_len[s] = '0;
					if (live > 0)
						live--;
				end
			end
		end
		if (s >= 0) begin
			r.found = 1'b1;
			r.ptr_out = tbl_ptr[s];
			r.length_out = tbl_len[s];
			r.slot_out = 10'(s);
			r.refcount_out = tbl_refs[s];
		end
		r.entry_count = live;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_beat(logic [2:0] cmd, logic [63:0] k, logic us, logic [9:0] sl,
			logic [63:0] pv, logic [63:0] ln);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'd0, ln, pv, sl, us, k};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note(table_step(cmd, k, us, sl, pv, ln));
	endtask

	task automatic rest(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return rand64();
	endfunction

	task automatic random_beat();
		logic [63:0] k, pv;
		logic [2:0] cmd;
		int sel, s;
		logic us;
		k = pick_key();
		pv = ($urandom_range(0, 15) == 0) ? 64'd0 : rand64();
		sel = $urandom_range(0, 99);
		us = 1'b0;
		s = $urandom_range(0, SLOTS - 1);
		if (sel < 30) begin
			cmd = bpht_pkg::CMD_SET;
			if (known_keys.size() < 200 && $urandom_range(0, 2) == 0)
				k = rand64();
			known_keys.push_back(k);
		end else if (sel < 55)
			cmd = bpht_pkg::CMD_LOOKUP;
		else if (sel < 75)
			cmd = bpht_pkg::CMD_INC;
		else if (sel < 95)
			cmd = bpht_pkg::CMD_DEC;
		else
			cmd = 3'(CMD_NOP + $urandom_range(0, 3));
		if (cmd != bpht_pkg::CMD_LOOKUP && $urandom_range(0, 4) == 0) begin
			us = 1'b1;
			// target a slot that is actually populated when the key is live
			if (cmd != bpht_pkg::CMD_SET && search_live(k) >= 0)
				s = search_live(k);
		end
		send_beat(cmd, k, us, 10'(s), pv, rand64());
	endtask

	initial begin
		logic [63:0] kz;
		int h;
		board = new();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_ptr[i] = '0;
			tbl_len[i] = '0;
			tbl_reach[i] = '0;
			tbl_refs[i] = '0;
		end
		live = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses, zero key, extremes, nop, reserved codes
		send_beat(bpht_pkg::CMD_LOOKUP, 64'd0, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_DEC, 64'hffff_ffff_ffff_ffff, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_INC, 64'd5, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_SET, 64'd0, 1'b0, 10'd0, '1, '1);
		send_beat(bpht_pkg::CMD_LOOKUP, 64'd0, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_SET, '1, 1'b0, 10'd0, 64'd1, 64'd0);
		send_beat(bpht_pkg::CMD_SET, 64'h1234, 1'b0, 10'd0, 64'd0, 64'd7);
		send_beat(bpht_pkg::CMD_LOOKUP, 64'h1234, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_INC, '1, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_DEC, '1, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_DEC, '1, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_LOOKUP, '1, 1'b0, 10'd0, '0, '0);
		send_beat(bpht_pkg::CMD_DEC, 64'd0, 1'b1, 10'd1023, '0, '0);
		send_beat(bpht_pkg::CMD_INC, 64'd0, 1'b1, 10'd1023, '0, '0);
		send_beat(bpht_pkg::CMD_SET, 64'd0, 1'b1, 10'd1023, '1, '1);
		send_beat(bpht_pkg::CMD_SET, 64'd0, 1'b1, 10'd0, 64'h5555, 64'haaaa);
		send_beat(CMD_NOP, '1, 1'b1, 10'd1023, '1, '1);
		send_beat(CMD_RSV_LAST, '0, 1'b0, 10'd0, '0, '0);
		// fill one home's probe window until it reports full
		kz = 64'h77;
		h = home_slot(kz);
		for (int i = 0; i < 17; i++)
			send_beat(bpht_pkg::CMD_SET, kz, 1'b0, 10'd0, 64'(i + 1), 64'(i));
		send_beat(bpht_pkg::CMD_LOOKUP, kz, 1'b0, 10'd0, '0, '0);
		known_keys.push_back(kz);
		drain();

		// random traffic with one long output stall and one full drain
		for (int n = 0; n < 1400; n++) begin
			if (n == 300) begin
				stall_long = 3000;
				for (int j = 0; j < 6; j++)
					random_beat();
			end
			if (n == 700)
				drain();
			if ($urandom_range(0, 5) == 0)
				rest($urandom_range(1, 40));
			random_beat();
		end
		drain();
		rest(100);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		stall_long = 0;
		forever begin
			@(posedge clk);
			if (stall_long > 0) begin
				m_tready <= 1'b0;
				repeat (stall_long) @(posedge clk);
				stall_long = 0;
			end
			if (cycles % 2000 < 600)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check(bpht_pkg::result_t'(m_tdata));
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule

// File: bounded_probe_hash_table_core.f
sv/bpht_pkg.sv
sv/bpht_ram.sv
sv/bounded_probe_hash_table_core.sv
dv/bounded_probe_hash_table_core_test.sv
